[src/nqbs_pkg.sv]
package nqbs_pkg;

    // Largest board the search handles by default.
    localparam int MAX_N_DEF = 16;

    // Fixed widths of the request and result fields.
    localparam int SIZE_W  = 5;
    localparam int FIELD_W = 4;

    // Shift command shared by every cell of the placement stack.
    typedef struct packed {
        logic push;
        logic pop;
    } nqbs_shift_t;

endpackage

[src/nqbs_cell.sv]
module nqbs_cell #(
    parameter int ROW_W = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nqbs_pkg::nqbs_shift_t ctl,
    input  logic [ROW_W-1:0]     up_in,
    input  logic [ROW_W-1:0]     down_in,
    output logic [ROW_W-1:0]     row
);
    import nqbs_pkg::*;

    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    // A push takes the row of the neighbor nearer the top of the stack,
    // a pop takes the row of the neighbor further down.
    always_comb
    begin
        row_next = row_reg;
        if (ctl.push)
        begin
            row_next = up_in;
        end
        else if (ctl.pop)
        begin
            row_next = down_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    assign row = row_reg;

endmodule

[src/n_queens_backtrack_solver.sv]
// Flow: the request is taken in ST_IDLE, then a depth-first search in which
// every step tries a column in ST_TRY and then places or backtracks in ST_STEP;
// once ST_TRY sees the board full, ST_ALIGN slides the placement stack to its
// output end, then n results go at one per cycle while res_stall is low, or one
// result when no placement exists. The search length depends on n and sets the
// rate. One request is taken at a time; req_stall is high until the last result
// goes. Reset is asynchronous and active low and returns the block to idle.
module n_queens_backtrack_solver #(
    parameter int MAX_N = nqbs_pkg::MAX_N_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic [nqbs_pkg::SIZE_W-1:0]  board_size,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic [nqbs_pkg::FIELD_W-1:0] column,
    output logic [nqbs_pkg::FIELD_W-1:0] placed_row,
    output logic                         found,
    output logic                         last
);
    import nqbs_pkg::*;

    localparam int ROW_W  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int N_W    = $clog2(MAX_N + 1);
    localparam int DIAG_N = 2 * MAX_N - 1;
    localparam int DI_W   = $clog2(2 * MAX_N);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TRY   = 3'd1;
    localparam logic [2:0] ST_STEP  = 3'd2;
    localparam logic [2:0] ST_ALIGN = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [N_W-1:0]    n_reg, n_next;
    logic [N_W-1:0]    col_reg, col_next;
    logic [N_W-1:0]    start_reg, start_next;
    logic [N_W-1:0]    k_reg, k_next;
    logic [N_W-1:0]    align_reg, align_next;
    logic              found_reg, found_next;
    logic              cand_ok_reg, cand_ok_next;
    logic [ROW_W-1:0]  cand_row_reg, cand_row_next;
    logic [MAX_N-1:0]  row_taken_reg, row_taken_next;
    logic [DIAG_N-1:0] diag_reg, diag_next;
    logic [DIAG_N-1:0] anti_reg, anti_next;

    nqbs_shift_t       shift;
    logic [ROW_W-1:0]  push_row;
    logic [ROW_W-1:0]  cell_row [MAX_N];

    logic [N_W-1:0]    n_sat;
    logic [DIAG_N-1:0] diag_view;
    logic [DIAG_N-1:0] anti_view;
    logic [DI_W-1:0]   anti_off;
    logic [MAX_N-1:0]  free_rows;
    logic              cand_ok;
    logic [ROW_W-1:0]  cand_row;

    logic [ROW_W-1:0]  mark_row;
    logic [N_W-1:0]    mark_col;
    logic [DI_W-1:0]   mark_d;
    logic [DI_W-1:0]   mark_a;
    logic [MAX_N-1:0]  row_bit;
    logic [DIAG_N-1:0] diag_bit;
    logic [DIAG_N-1:0] anti_bit;
    logic              is_last;

    // Placement stack: cell 0 holds the row of the most recent column.
    for (genvar i = 0; i < MAX_N; i++)
    begin : g_cell
        logic [ROW_W-1:0] up_row;
        logic [ROW_W-1:0] down_row;
        if (i == 0)
        begin : g_head
            assign up_row = push_row;
        end
        else
        begin : g_body
            assign up_row = cell_row[i-1];
        end
        if (i == MAX_N - 1)
        begin : g_tail
            assign down_row = '0;
        end
        else
        begin : g_inner
            assign down_row = cell_row[i+1];
        end
        nqbs_cell #(
            .ROW_W (ROW_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (shift),
            .up_in   (up_row),
            .down_in (down_row),
            .row     (cell_row[i])
        );
    end

    assign n_sat = (32'(board_size) > MAX_N) ? N_W'(MAX_N) : N_W'(board_size);

    // Free rows of the current column, at or above the restart row.
    assign diag_view = diag_reg >> col_reg;
    assign anti_off  = DI_W'(n_reg) - DI_W'(1) - DI_W'(col_reg);
    assign anti_view = anti_reg >> anti_off;

    always_comb
    begin
        for (int r = 0; r < MAX_N; r++)
        begin
            free_rows[r] = !row_taken_reg[r] && !diag_view[r] && !anti_view[r]
                           && (start_reg <= N_W'(r)) && (N_W'(r) < n_reg);
        end
    end

    always_comb
    begin
        cand_row = '0;
        for (int r = MAX_N - 1; r >= 0; r--)
        begin
            if (free_rows[r])
            begin
                cand_row = ROW_W'(r);
            end
        end
    end

    assign cand_ok = |free_rows;

    // The same bit positions serve to place a queen and to lift the top one.
    assign mark_row = cand_ok_reg ? cand_row_reg : cell_row[0];
    assign mark_col = cand_ok_reg ? col_reg : N_W'(col_reg - N_W'(1));
    assign mark_d   = DI_W'(mark_row) + DI_W'(mark_col);
    assign mark_a   = DI_W'(mark_row) + DI_W'(n_reg) - DI_W'(1) - DI_W'(mark_col);
    assign row_bit  = MAX_N'(1) << mark_row;
    assign diag_bit = DIAG_N'(1) << mark_d;
    assign anti_bit = DIAG_N'(1) << mark_a;

    assign is_last = !found_reg || (k_reg == N_W'(n_reg - N_W'(1)));

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        col_next       = col_reg;
        start_next     = start_reg;
        k_next         = k_reg;
        align_next     = align_reg;
        found_next     = found_reg;
        cand_ok_next   = cand_ok_reg;
        cand_row_next  = cand_row_reg;
        row_taken_next = row_taken_reg;
        diag_next      = diag_reg;
        anti_next      = anti_reg;
        shift          = '0;
        push_row       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    n_next         = n_sat;
                    col_next       = '0;
                    start_next     = '0;
                    k_next         = '0;
                    row_taken_next = '0;
                    diag_next      = '0;
                    anti_next      = '0;
                    if (n_sat == '0)
                    begin
                        found_next = 1'b0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_TRY;
                    end
                end
            end
            ST_TRY:
            begin
                if (col_reg == n_reg)
                begin
                    found_next = 1'b1;
                    align_next = N_W'(MAX_N) - n_reg;
                    state_next = ST_ALIGN;
                end
                else
                begin
                    cand_ok_next  = cand_ok;
                    cand_row_next = cand_row;
                    state_next    = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (cand_ok_reg)
                begin
                    row_taken_next = row_taken_reg | row_bit;
                    diag_next      = diag_reg | diag_bit;
                    anti_next      = anti_reg | anti_bit;
                    shift.push     = 1'b1;
                    push_row       = cand_row_reg;
                    col_next       = col_reg + N_W'(1);
                    start_next     = '0;
                    state_next     = ST_TRY;
                end
                else if (col_reg == '0)
                begin
                    found_next = 1'b0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    row_taken_next = row_taken_reg & ~row_bit;
                    diag_next      = diag_reg & ~diag_bit;
                    anti_next      = anti_reg & ~anti_bit;
                    shift.pop      = 1'b1;
                    start_next     = N_W'(cell_row[0]) + N_W'(1);
                    col_next       = col_reg - N_W'(1);
                    state_next     = ST_TRY;
                end
            end
            ST_ALIGN:
            begin
                // Column 0 has to reach the far end of the stack first.
                if (align_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    shift.push = 1'b1;
                    align_next = align_reg - N_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (!res_stall)
                begin
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        shift.push = 1'b1;
                        k_next     = k_reg + N_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            found_reg   <= 1'b0;
            cand_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            found_reg   <= found_next;
            cand_ok_reg <= cand_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        col_reg       <= col_next;
        start_reg     <= start_next;
        k_reg         <= k_next;
        align_reg     <= align_next;
        cand_row_reg  <= cand_row_next;
        row_taken_reg <= row_taken_next;
        diag_reg      <= diag_next;
        anti_reg      <= anti_next;
    end

    assign req_stall  = (state_reg != ST_IDLE);
    assign res_valid  = (state_reg == ST_EMIT);
    assign column     = found_reg ? FIELD_W'(k_reg) : '0;
    assign placed_row = found_reg ? FIELD_W'(cell_row[MAX_N-1]) : '0;
    assign found      = found_reg;
    assign last       = is_last;

endmodule

[src/nqbs_checker.sv]
module nqbs_sva (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_stall,
    input logic [nqbs_pkg::SIZE_W-1:0]  board_size,
    input logic                         res_valid,
    input logic                         res_stall,
    input logic [nqbs_pkg::FIELD_W-1:0] column,
    input logic [nqbs_pkg::FIELD_W-1:0] placed_row,
    input logic                         found,
    input logic                         last
);
    import nqbs_pkg::*;

    logic [SIZE_W-1:0] size_seen;

    assign size_seen = board_size;

    // A stalled result holds still.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(column)
            && $stable(placed_row) && $stable(found) && $stable(last))
        else $error("result changed while stalled");

    // Once an item is taken the block is busy until its results are gone.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request side not stalled after accepting an item");

    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> req_stall)
        else $error("request side open while a result is pending");

    // A failed search gives a single empty result.
    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !found |-> last && column == '0 && placed_row == '0)
        else $error("failure result malformed");

    // Results of a solution follow one another in column order.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && !last && size_seen == size_seen
        |=> res_valid && found && column == FIELD_W'($past(column) + 1'b1))
        else $error("results out of column order");

endmodule

bind n_queens_backtrack_solver nqbs_sva u_nqbs_sva (.*);
